FILE: rtl/sit_pkg.sv
`timescale 1ns / 1ps

package sit_pkg;

    localparam int ID_W    = 16;
    localparam int CODE_W  = 2;
    localparam int POS_W   = 7;
    localparam int FILL_W  = 7;
    localparam int KEY_W   = 2 * CODE_W;
    localparam int TDATA_W = 32;

    // Operation selected by the input tuser bit.
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_READ   = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    // The key is {kind, grade}, which sits in the low bits of the packed record.
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [CODE_W-1:0] kind;
        logic [CODE_W-1:0] grade;
    } entry_t;

    // Broadcast from the top level to every cell of the row.
    typedef struct packed {
        logic   ins;
        entry_t new_entry;
    } cell_ctrl_t;

endpackage

FILE: rtl/sit_cell.sv
`timescale 1ns / 1ps

module sit_cell (
    input  logic               aclk,
    input  sit_pkg::cell_ctrl_t ctrl,
    input  logic               slot_valid,
    input  logic               left_gt,
    input  sit_pkg::entry_t    left_entry,
    output logic               gt,
    output sit_pkg::entry_t    entry
);
    import sit_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // An empty slot counts as holding a larger key, so the first empty slot
    // takes the new record when no stored key is larger.
    assign gt = !slot_valid ||
                ({entry_reg.kind, entry_reg.grade} >
                 {ctrl.new_entry.kind, ctrl.new_entry.grade});

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.ins && gt) begin
            entry_next = left_gt ? left_entry : ctrl.new_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

FILE: rtl/sorted_insert_table.sv
`timescale 1ns / 1ps
// Sorted record table. Records of a 16-bit id, a 2-bit kind and a 2-bit grade
// are kept ordered by kind, then grade; a new record goes after every stored
// record with an equal or smaller key, so equal keys keep arrival order.
// Input channel (s_axis_*): tuser selects insert (0) or read (1); tdata carries
// the record to insert and the index to read. Output channel (m_axis_*): one
// transfer per input transfer, with the status in tuser and the record read
// plus the updated fill count in tdata.
// Each item is done in the cycle it is accepted: the row of cells compares
// the new key against every stored key in parallel and shifts in one step,
// so one item is taken per cycle unless a stalled receiver holds it back.
// The result sits in an output register; the input is still accepted while
// that register is drained in the same cycle, so a stalled receiver only
// holds back the input once one result is waiting.
// Reset clears the fill count and the output valid; the record slots are not
// cleared, since only slots below the fill count are ever read.
module sorted_insert_table #(
    parameter int CAPACITY = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [15:0] record_id, [17:16] kind, [19:18] grade, [26:20] position
    input  logic [sit_pkg::TDATA_W-1:0]   s_axis_tdata,
    // [0] mode
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [15:0] out_id, [17:16] out_kind, [19:18] out_grade, [26:20] fill
    output logic [sit_pkg::TDATA_W-1:0]   m_axis_tdata,
    // [1:0] status
    output logic [1:0]                    m_axis_tuser
);
    import sit_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    // Input unpacking.
    logic                s_acc;
    logic                in_mode;
    entry_t              in_entry;
    logic [POS_W-1:0]    in_pos;

    assign s_acc          = s_axis_tvalid && s_axis_tready;
    assign in_mode        = s_axis_tuser;
    assign in_entry.id    = s_axis_tdata[15:0];
    assign in_entry.kind  = s_axis_tdata[17:16];
    assign in_entry.grade = s_axis_tdata[19:18];
    assign in_pos         = s_axis_tdata[26:20];

    // Fill count.
    logic [CW-1:0] occupancy_reg;
    logic [CW-1:0] occupancy_next;
    logic          full;
    logic          do_insert;

    assign full      = (occupancy_reg == CW'(CAPACITY));
    assign do_insert = s_acc && (in_mode == MODE_INSERT) && !full;

    always_comb begin
        occupancy_next = occupancy_reg;
        if (do_insert) begin
            occupancy_next = occupancy_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occupancy_reg <= '0;
        end else begin
            occupancy_reg <= occupancy_next;
        end
    end

    // Row of cells. Each cell either keeps its record, takes the new one, or
    // takes its left neighbor's record as the tail shifts up by one slot.
    cell_ctrl_t            ctrl;
    entry_t                cell_entry [CAPACITY];
    logic [CAPACITY-1:0]   cell_gt;

    assign ctrl.ins       = do_insert;
    assign ctrl.new_entry = in_entry;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic   left_gt;
        entry_t left_entry;

        if (i == 0) begin : g_first
            assign left_gt    = 1'b0;
            assign left_entry = '0;
        end else begin : g_rest
            assign left_gt    = cell_gt[i-1];
            assign left_entry = cell_entry[i-1];
        end

        sit_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .slot_valid (occupancy_reg > CW'(i)),
            .left_gt    (left_gt),
            .left_entry (left_entry),
            .gt         (cell_gt[i]),
            .entry      (cell_entry[i])
        );
    end

    // Read select over the row, gated so that an out-of-range read yields zero.
    logic [CMPW-1:0] pos_ext;
    logic [CMPW-1:0] occ_ext;
    logic            in_range;
    entry_t          rd_entry;

    assign pos_ext  = CMPW'(in_pos);
    assign occ_ext  = CMPW'(occupancy_reg);
    assign in_range = (pos_ext < occ_ext);

    always_comb begin
        rd_entry = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (in_range && (pos_ext == CMPW'(i))) begin
                rd_entry = cell_entry[i];
            end
        end
    end

    // Result formation.
    status_t             res_status;
    entry_t              res_entry;

    always_comb begin
        res_status = ST_OK;
        res_entry  = '0;
        if (in_mode == MODE_INSERT) begin
            if (full) begin
                res_status = ST_FULL;
            end
        end else begin
            if (in_range) begin
                res_entry = rd_entry;
            end else begin
                res_status = ST_RANGE;
            end
        end
    end

    // Output register.
    logic                m_valid_reg;
    logic                m_valid_next;
    logic [TDATA_W-1:0]  m_data_reg;
    logic [TDATA_W-1:0]  m_data_next;
    status_t             m_status_reg;
    status_t             m_status_next;

    assign s_axis_tready = !m_valid_reg || m_axis_tready;

    always_comb begin
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_status_next = m_status_reg;
        if (s_acc) begin
            m_valid_next  = 1'b1;
            m_data_next   = {5'd0, FILL_W'(occupancy_next), res_entry.grade,
                             res_entry.kind, res_entry.id};
            m_status_next = res_status;
        end else if (m_axis_tready) begin
            m_valid_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg   <= m_data_next;
        m_status_reg <= m_status_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_status_reg;

    // Checks.
    a_occ_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        occupancy_reg <= CW'(CAPACITY))
        else $error("fill count beyond capacity");

    a_full_refused : assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && (in_mode == MODE_INSERT) && full) |=>
        (m_axis_tuser == ST_FULL) && $stable(occupancy_reg))
        else $error("insert into full table not refused");

    a_insert_counts : assert property (@(posedge aclk) disable iff (!aresetn)
        do_insert |=> (occupancy_reg == CW'($past(occupancy_reg) + 1'b1)))
        else $error("insert did not advance fill count");

    a_range_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (m_axis_tuser == ST_RANGE)) |-> (m_axis_tdata[19:0] == '0))
        else $error("out-of-range read returned a record");

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import sit_pkg::*;

    localparam int CAP = 64;

    // One result as the table reports it: the status, the record read and the fill count.
    typedef struct packed {
        status_t           status;
        entry_t            rec;
        logic [FILL_W-1:0] fill;
    } outcome_t;

    // One input transfer. When fixed is set, want is the result that was typed in by hand
    // and is expected in place of the predicted one.
    typedef struct packed {
        logic             mode;
        entry_t           rec;
        logic [POS_W-1:0] pos;
        bit               fixed;
        outcome_t         want;
    } step_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [TDATA_W-1:0]  s_axis_tdata = '0;
    logic                s_axis_tuser = MODE_INSERT;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]  m_axis_tdata;
    logic [1:0]          m_axis_tuser;

    sorted_insert_table #(
        .CAPACITY(CAP)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Predictor state: its own copy of the sorted table and its fill count.
    entry_t   model_rows [CAP];
    int       model_fill = 0;

    // Results owed by the table, oldest first.
    outcome_t due_results [$];

    // The transfer currently offered on the input side, seen by the scoreboard at the
    // edge where it is accepted.
    step_t    offered = '0;

    int       errors = 0;
    int       checked = 0;
    int       n_added = 0;
    int       n_refused = 0;
    int       n_hits = 0;
    int       n_misses = 0;

    // Receiver stall bookkeeping; rx_burst turns off the stalls for a stretch.
    int       hold = 0;
    bit       rx_burst = 1'b0;
    bit       tx_burst = 1'b0;

    // Stable sorted insertion: a new record lands in front of the first stored record
    // whose {kind, grade} key is strictly larger, so equal keys keep arrival order.
    function automatic outcome_t table_step(logic mode, entry_t rec, logic [POS_W-1:0] pos);
        outcome_t o;
        int       slot;
        o = '0;
        o.status = ST_OK;
        if (mode == MODE_INSERT) begin
            if (model_fill >= CAP) begin
                o.status = ST_FULL;
            end else begin
                slot = model_fill;
                for (int i = model_fill - 1; i >= 0; i--) begin
                    if ({model_rows[i].kind, model_rows[i].grade} > {rec.kind, rec.grade})
                        slot = i;
                end
                for (int i = model_fill; i > slot; i--)
                    model_rows[i] = model_rows[i-1];
                model_rows[slot] = rec;
                model_fill++;
            end
        end else begin
            if (int'(pos) >= model_fill)
                o.status = ST_RANGE;
            else
                o.rec = model_rows[pos];
        end
        o.fill = FILL_W'(model_fill);
        return o;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        if (errors < 30)
            $display("[%0t] result %0d: %s is %0h, expected %0h", $realtime, checked, what,
                     got, want);
        errors++;
    endtask

    // Scoreboard and receiver. Input acceptance runs the predictor before the output
    // side is checked, so an expectation is always queued ahead of its result.
    always @(posedge aclk) begin : scoreboard
        outcome_t got;
        outcome_t want;
        outcome_t model;
        if (!aresetn) begin
            hold = 0;
            m_axis_tready <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                model = table_step(offered.mode, offered.rec, offered.pos);
                case (model.status)
                    ST_FULL:  n_refused++;
                    ST_RANGE: n_misses++;
                    default: begin
                        if (offered.mode == MODE_INSERT)
                            n_added++;
                        else
                            n_hits++;
                    end
                endcase
                due_results.insert(due_results.size(), offered.fixed ? offered.want : model);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.status    = status_t'(m_axis_tuser);
                got.rec.id    = m_axis_tdata[15:0];
                got.rec.kind  = m_axis_tdata[17:16];
                got.rec.grade = m_axis_tdata[19:18];
                got.fill      = m_axis_tdata[26:20];
                if (due_results.size() == 0) begin
                    report_mismatch("unexpected transfer, id", got.rec.id, 0);
                end else begin
                    want = due_results.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.rec.id != want.rec.id)
                        report_mismatch("out_id", got.rec.id, want.rec.id);
                    if (got.rec.kind != want.rec.kind)
                        report_mismatch("out_kind", got.rec.kind, want.rec.kind);
                    if (got.rec.grade != want.rec.grade)
                        report_mismatch("out_grade", got.rec.grade, want.rec.grade);
                    if (got.fill != want.fill)
                        report_mismatch("fill", got.fill, want.fill);
                end
                checked++;
                hold = rx_burst ? 0 : $urandom_range(0, 7);
                if ($urandom_range(0, 49) == 0)
                    rx_burst = !rx_burst;
            end else if (hold > 0) begin
                hold--;
            end
            m_axis_tready <= (hold == 0);
        end
    end

    // Offers one transfer after a random gap and returns at the edge where it is taken.
    // With no gap, tvalid simply stays high and only the payload changes.
    task automatic send(input step_t s);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 7);
        if ($urandom_range(0, 49) == 0)
            tx_burst = !tx_burst;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, s.pos, s.rec.grade, s.rec.kind, s.rec.id};
        s_axis_tuser  <= s.mode;
        offered       <= s;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    // Holds the input off until every owed result has come back. The first wait lets
    // the scoreboard queue the transfer accepted at the current edge.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (due_results.size() != 0);
    endtask

    step_t dir_rows [$];

    task automatic row(input logic mode, input logic [15:0] id, input logic [1:0] kind,
                       input logic [1:0] grade, input logic [6:0] pos, input bit fixed,
                       input status_t st, input logic [15:0] want_id,
                       input logic [1:0] want_kind, input logic [1:0] want_grade,
                       input logic [6:0] want_fill);
        step_t s;
        s.mode           = mode;
        s.rec.id         = id;
        s.rec.kind       = kind;
        s.rec.grade      = grade;
        s.pos            = pos;
        s.fixed          = fixed;
        s.want.status    = st;
        s.want.rec.id    = want_id;
        s.want.rec.kind  = want_kind;
        s.want.rec.grade = want_grade;
        s.want.fill      = want_fill;
        dir_rows.insert(dir_rows.size(), s);
    endtask

    // Random transfer. Reads mostly hit stored rows; a fifth of them pick any index,
    // which also reaches the top position bits. Unused fields always carry noise.
    function automatic step_t random_item(bit as_insert, int fill_now);
        step_t s;
        s = '0;
        s.mode      = as_insert ? MODE_INSERT : MODE_READ;
        s.rec.id    = 16'($urandom());
        s.rec.kind  = 2'($urandom_range(0, 3));
        s.rec.grade = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 15) == 0)
            s.rec.id = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        if (!as_insert && fill_now > 0 && $urandom_range(0, 4) != 0)
            s.pos = POS_W'($urandom_range(0, fill_now - 1));
        else
            s.pos = POS_W'($urandom_range(0, 127));
        return s;
    endfunction

    initial begin : stimulus
        int stim_fill;
        bit ins;

        // Directed rows. Only results that are obvious by hand are typed in: the empty
        // table, the two extreme records and the reads that fall past the fill count.
        row(MODE_READ,   16'h0000, 2'd0, 2'd0, 7'd0,   1, ST_RANGE, 16'h0000, 0, 0, 7'd0);
        row(MODE_READ,   16'hFFFF, 2'd3, 2'd3, 7'd127, 1, ST_RANGE, 16'h0000, 0, 0, 7'd0);
        row(MODE_INSERT, 16'hFFFF, 2'd3, 2'd3, 7'd127, 1, ST_OK,    16'h0000, 0, 0, 7'd1);
        row(MODE_INSERT, 16'h0000, 2'd0, 2'd0, 7'd0,   1, ST_OK,    16'h0000, 0, 0, 7'd2);
        row(MODE_READ,   16'hFFFF, 2'd3, 2'd3, 7'd0,   1, ST_OK,    16'h0000, 0, 0, 7'd2);
        row(MODE_READ,   16'h0000, 2'd0, 2'd0, 7'd1,   1, ST_OK,    16'hFFFF, 3, 3, 7'd2);
        row(MODE_READ,   16'h0000, 2'd0, 2'd0, 7'd2,   1, ST_RANGE, 16'h0000, 0, 0, 7'd2);
        // Equal keys must land in arrival order, and a key equal to the largest or
        // smallest stored key goes after it.
        row(MODE_INSERT, 16'h1234, 2'd1, 2'd2, 7'd64,  0, ST_OK, 0, 0, 0, 0);
        row(MODE_INSERT, 16'h5678, 2'd1, 2'd2, 7'd5,   0, ST_OK, 0, 0, 0, 0);
        row(MODE_INSERT, 16'hAAAA, 2'd2, 2'd0, 7'd0,   0, ST_OK, 0, 0, 0, 0);
        row(MODE_INSERT, 16'h5555, 2'd0, 2'd3, 7'd42,  0, ST_OK, 0, 0, 0, 0);
        row(MODE_INSERT, 16'h0001, 2'd3, 2'd3, 7'd1,   0, ST_OK, 0, 0, 0, 0);
        row(MODE_INSERT, 16'h8000, 2'd0, 2'd0, 7'd85,  0, ST_OK, 0, 0, 0, 0);
        for (int i = 0; i < 8; i++)
            row(MODE_READ, 16'h00FF << i, 2'(i), 2'(~i), 7'(i), 0, ST_OK, 0, 0, 0, 0);
        row(MODE_READ,   16'h0000, 2'd0, 2'd0, 7'd8,   1, ST_RANGE, 16'h0000, 0, 0, 7'd8);
        row(MODE_READ,   16'hFFFF, 2'd3, 2'd3, 7'd64,  1, ST_RANGE, 16'h0000, 0, 0, 7'd8);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i])
            send(dir_rows[i]);
        stim_fill = 8;
        drain();

        // Fill the table up with random records, reading back along the way, so the
        // full-table refusal is always reached.
        while (stim_fill < CAP) begin
            ins = ($urandom_range(0, 9) < 6);
            send(random_item(ins, stim_fill));
            if (ins)
                stim_fill++;
        end

        // From here on the table stays full: mostly reads, with refused inserts mixed in.
        for (int n = 0; n < 1900; n++) begin
            if (n == 950)
                drain();
            send(random_item($urandom_range(0, 4) == 0, stim_fill));
        end

        drain();
        repeat (8) @(posedge aclk);

        $display("Covered %0d stored inserts, %0d refused on a full table, %0d reads",
                 n_added, n_refused, n_hits + n_misses);
        $display("(%0d past the fill count); %0d result transfers checked.", n_misses,
                 checked);
        if (errors == 0 && due_results.size() == 0) begin
            $display("PASS sorted_insert_table");
        end else begin
            $display("FAIL sorted_insert_table");
        end
        $finish;
    end

    // Watchdog: set far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("FAIL sorted_insert_table");
        $finish;
    end

endmodule

FILE: sorted_insert_table.f
rtl/sit_pkg.sv
rtl/sit_cell.sv
rtl/sorted_insert_table.sv
bench/testbench.sv
